// File: sv/gnt_pkg.sv
package gnt_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] WANT_CLASS  = 8'h01;
    localparam logic [7:0] WANT_KIND   = 8'h06;
    localparam logic [7:0] TX_START    = 8'h99;
    localparam logic [7:0] TX_LEN      = 8'd20;

    localparam int CAP_FIRST = 10;
    localparam int CAP_COUNT = 14;
    localparam int CAP_SENT  = CAP_COUNT - 1;

    localparam int MAX_PAYLOAD_DEFAULT = 512;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic REG_AIRCRAFT_ID = 1'b0;
    localparam logic REG_MSG_ID      = 1'b1;

    localparam logic [7:0] AIRCRAFT_ID_RESET = 8'd1;
    localparam logic [7:0] MSG_ID_RESET      = 8'd14;

    // fix byte, then payload bytes 12..23
    typedef logic [CAP_SENT-1:0][7:0] tlm_entry_t;

    typedef struct packed {
        logic       push;
        tlm_entry_t data;
    } gnt_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gnt_qstat_t;

endpackage

// File: sv/gps_nav_frame_to_telemetry_bridge_core.sv
// a good frame is queued on its second checksum beat, then fed to the output register
// one beat per cycle in, and out while m_tready is high; 20 beats per frame
// s_tready drops only on the second checksum beat while the frame queue is full
// reset: aresetn synchronous active low; parser hunts for sync, queue empties,
// registers return to aircraft id 1 and message id 14, capture bytes clear
module gps_nav_frame_to_telemetry_bridge_core #(
    parameter int MAX_PAYLOAD = gnt_pkg::MAX_PAYLOAD_DEFAULT,
    parameter int QUEUE_DEPTH = gnt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // tx_byte
    output logic       m_tlast
);
    import gnt_pkg::*;

    gnt_push_t  push;
    gnt_qstat_t qstat;
    tlm_entry_t head;
    logic       pop;

    gnt_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .qstat   (qstat),
        .push    (push)
    );

    gnt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .qstat  (qstat)
    );

    gnt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sv/gnt_front.sv
module gnt_front #(
    parameter int MAX_PAYLOAD = gnt_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  gnt_pkg::gnt_qstat_t qstat,
    output gnt_pkg::gnt_push_t  push
);
    import gnt_pkg::*;

    localparam int IW = $clog2(MAX_PAYLOAD + 1);

    localparam logic [3:0] PH_SYNC1 = 4'd0;
    localparam logic [3:0] PH_SYNC2 = 4'd1;
    localparam logic [3:0] PH_CLASS = 4'd2;
    localparam logic [3:0] PH_KIND  = 4'd3;
    localparam logic [3:0] PH_LENLO = 4'd4;
    localparam logic [3:0] PH_LENHI = 4'd5;
    localparam logic [3:0] PH_PAY   = 4'd6;
    localparam logic [3:0] PH_CKA   = 4'd7;
    localparam logic [3:0] PH_CKB   = 4'd8;

    logic [3:0]    phase_reg, phase_next;
    logic [7:0]    class_reg, class_next;
    logic [7:0]    kind_reg, kind_next;
    logic [15:0]   len_reg, len_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]    suma_reg, suma_next;
    logic [7:0]    sumb_reg, sumb_next;
    logic [7:0]    rsuma_reg, rsuma_next;
    logic [CAP_COUNT-1:0][7:0] cap_reg, cap_next;

    logic       accept;
    logic [7:0] add_a;
    logic [15:0] len_full;
    logic       good;

    assign s_tready = !(phase_reg == PH_CKB && qstat.full);
    assign accept   = s_tvalid && s_tready;
    assign add_a    = suma_reg + s_tdata;
    assign len_full = {s_tdata, len_reg[7:0]};
    assign good     = (suma_reg == rsuma_reg) && (sumb_reg == s_tdata) &&
                      (class_reg == WANT_CLASS) && (kind_reg == WANT_KIND);

    always_comb begin
        push.push    = accept && phase_reg == PH_CKB && good;
        push.data[0] = cap_reg[0];
        for (int i = 1; i < CAP_SENT; i++) begin
            push.data[i] = cap_reg[i+1];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        class_next = class_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        suma_next  = suma_reg;
        sumb_next  = sumb_reg;
        rsuma_next = rsuma_reg;
        cap_next   = cap_reg;
        if (accept) begin
            case (phase_reg)
                PH_SYNC1: begin
                    suma_next = 8'd0;
                    sumb_next = 8'd0;
                    if (s_tdata == SYNC_FIRST) phase_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    phase_next = (s_tdata == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS, PH_KIND, PH_LENLO, PH_LENHI, PH_PAY: begin
                    suma_next = add_a;
                    sumb_next = sumb_reg + add_a;
                    case (phase_reg)
                        PH_CLASS: begin
                            class_next = s_tdata;
                            phase_next = PH_KIND;
                        end
                        PH_KIND: begin
                            kind_next  = s_tdata;
                            phase_next = PH_LENLO;
                        end
                        PH_LENLO: begin
                            len_next   = {8'd0, s_tdata};
                            phase_next = PH_LENHI;
                        end
                        PH_LENHI: begin
                            len_next   = len_full;
                            idx_next   = '0;
                            phase_next = (len_full > 16'(MAX_PAYLOAD)) ? PH_SYNC1 : PH_PAY;
                        end
                        default: begin
                            for (int i = 0; i < CAP_COUNT; i++) begin
                                if (idx_reg == IW'(CAP_FIRST + i)) cap_next[i] = s_tdata;
                            end
                            idx_next = idx_reg + 1'b1;
                            if (16'(idx_next) >= len_reg) phase_next = PH_CKA;
                        end
                    endcase
                end
                PH_CKA: begin
                    rsuma_next = s_tdata;
                    phase_next = PH_CKB;
                end
                PH_CKB: begin
                    phase_next = PH_SYNC1;
                end
                default: begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            class_reg <= '0;
            kind_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            suma_reg  <= '0;
            sumb_reg  <= '0;
            rsuma_reg <= '0;
            cap_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            suma_reg  <= suma_next;
            sumb_reg  <= sumb_next;
            rsuma_reg <= rsuma_next;
            cap_reg   <= cap_next;
        end
    end

    a_stall_only_ckb: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (phase_reg == PH_CKB && qstat.full))
        else $error("front stalled outside checksum phase");
    a_push_ckb: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push |=> phase_reg == PH_SYNC1)
        else $error("push not followed by sync hunt");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAY |-> len_reg <= 16'(MAX_PAYLOAD))
        else $error("payload phase with oversize length");
    a_cka_after_pay: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CKA) |-> $past(phase_reg == PH_PAY || phase_reg == PH_CKA))
        else $error("checksum phase entered out of order");

endmodule

// File: sv/gnt_queue.sv
module gnt_queue #(
    parameter int DEPTH = gnt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gnt_pkg::gnt_push_t  push,
    input  logic                pop,
    output gnt_pkg::tlm_entry_t head,
    output gnt_pkg::gnt_qstat_t qstat
);
    import gnt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tlm_entry_t    mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign qstat.full  = (cnt_reg == CW'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push.push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wptr_reg] <= push.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)  rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push.push && qstat.full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && qstat.empty))
        else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// File: sv/gnt_back.sv
module gnt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [7:0]          cfg_wdata,
    input  gnt_pkg::tlm_entry_t head,
    input  gnt_pkg::gnt_qstat_t qstat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import gnt_pkg::*;

    localparam logic [4:0] POS_LAST = 5'd19;

    logic [7:0] aid_reg, mid_reg;
    logic [4:0] pos_reg;
    logic [7:0] ta_reg, tb_reg, ta_next, tb_next;
    logic       tvalid_reg;
    logic [7:0] tdata_reg;
    logic       tlast_reg;

    logic       load, emit;
    logic [7:0] byte_sel;
    logic [3:0] eidx;

    assign load = !tvalid_reg || m_tready;
    assign emit = load && !qstat.empty;
    assign pop  = emit && pos_reg == POS_LAST;
    assign eidx = 4'(pos_reg - 5'd5);

    always_comb begin
        case (pos_reg)
            5'd0:  byte_sel = TX_START;
            5'd1:  byte_sel = TX_LEN;
            5'd2:  byte_sel = aid_reg;
            5'd3:  byte_sel = mid_reg;
            5'd4:  byte_sel = aid_reg;
            5'd18: byte_sel = ta_reg;
            5'd19: byte_sel = tb_reg;
            default: byte_sel = (eidx < 4'(CAP_SENT)) ? head[eidx] : 8'd0;
        endcase
    end

    always_comb begin
        ta_next = ta_reg;
        tb_next = tb_reg;
        if (emit) begin
            if (pos_reg == POS_LAST) begin
                ta_next = TX_LEN;
                tb_next = TX_LEN;
            end else if (pos_reg inside {[5'd2:5'd17]}) begin
                ta_next = ta_reg + byte_sel;
                tb_next = tb_reg + ta_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aid_reg <= AIRCRAFT_ID_RESET;
            mid_reg <= MSG_ID_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_AIRCRAFT_ID: aid_reg <= cfg_wdata;
                REG_MSG_ID:      mid_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            ta_reg     <= TX_LEN;
            tb_reg     <= TX_LEN;
            tvalid_reg <= 1'b0;
        end else begin
            ta_reg <= ta_next;
            tb_reg <= tb_next;
            if (load) tvalid_reg <= emit;
            if (emit) pos_reg <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            tdata_reg <= byte_sel;
            tlast_reg <= (pos_reg == POS_LAST);
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    a_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == 5'd0 |-> (ta_reg == TX_LEN && tb_reg == TX_LEN))
        else $error("sums not seeded at frame start");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("byte position out of range");
    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_tvalid && m_tlast && pos_reg == 5'd0))
        else $error("frame end not marked on last beat");

endmodule

// File: dv/gps_nav_frame_to_telemetry_bridge_core_tb.sv
module gps_nav_frame_to_telemetry_bridge_core_tb;

    import gnt_pkg::*;

    localparam int MAX_LEN    = MAX_PAYLOAD_DEFAULT;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_PCT   = 12;
    localparam int PHASE_BEATS = 25;

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CLASS, PH_KIND, PH_LEN_LO, PH_LEN_HI,
        PH_PAYLOAD, PH_CK_A, PH_CK_B
    } parse_phase_e;

    typedef enum int {
        CK_GOOD, CK_BAD_A, CK_BAD_B, CK_BAD_BOTH
    } ck_fault_e;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    class telemetry_scoreboard;
        logic [7:0]   aircraft_id;
        logic [7:0]   msg_id;
        parse_phase_e phase;
        logic [7:0]   frame_class;
        logic [7:0]   frame_kind;
        logic [7:0]   sum_a;
        logic [7:0]   sum_b;
        logic [7:0]   rx_sum_a;
        int unsigned  frame_len;
        int unsigned  frame_idx;
        logic [7:0]   capture [CAP_COUNT];
        tx_beat_t     tlm_expected [$];
        int           errors;
        int           frames_checked;

        function new();
            aircraft_id = AIRCRAFT_ID_RESET;
            msg_id = MSG_ID_RESET;
            phase = PH_SYNC1;
            frame_class = '0;
            frame_kind = '0;
            sum_a = '0;
            sum_b = '0;
            rx_sum_a = '0;
            frame_len = 0;
            frame_idx = 0;
            foreach (capture[i]) capture[i] = '0;
            errors = 0;
            frames_checked = 0;
        endfunction

        function void set_reg(logic addr, logic [7:0] value);
            if (addr == REG_AIRCRAFT_ID) aircraft_id = value;
            else msg_id = value;
        endfunction

        function void add_sum(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void push_tx(logic [7:0] b, bit summed, inout logic [7:0] ta,
                              inout logic [7:0] tb);
            tx_beat_t beat;
            if (summed) begin
                ta = ta + b;
                tb = tb + ta;
            end
            beat.data = b;
            beat.last = 1'b0;
            tlm_expected.push_back(beat);
        endfunction

        function void emit_telemetry();
            logic [7:0] ta;
            logic [7:0] tb;
            tx_beat_t   beat;
            ta = TX_LEN;
            tb = TX_LEN;
            push_tx(TX_START, 0, ta, tb);
            push_tx(TX_LEN, 0, ta, tb);
            push_tx(aircraft_id, 1, ta, tb);
            push_tx(msg_id, 1, ta, tb);
            push_tx(aircraft_id, 1, ta, tb);
            push_tx(capture[0], 1, ta, tb);
            for (int i = 2; i < CAP_COUNT; i++) push_tx(capture[i], 1, ta, tb);
            beat.data = ta;
            beat.last = 1'b0;
            tlm_expected.push_back(beat);
            beat.data = tb;
            beat.last = 1'b1;
            tlm_expected.push_back(beat);
        endfunction

        function void take_rx_byte(logic [7:0] b);
            case (phase)
                PH_SYNC1: begin
                    sum_a = '0;
                    sum_b = '0;
                    if (b == SYNC_FIRST) phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    phase = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                end
                PH_CLASS: begin
                    frame_class = b;
                    add_sum(b);
                    phase = PH_KIND;
                end
                PH_KIND: begin
                    frame_kind = b;
                    add_sum(b);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len = b;
                    add_sum(b);
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    frame_len = frame_len | (int'(b) << 8);
                    add_sum(b);
                    frame_idx = 0;
                    phase = (frame_len > MAX_LEN) ? PH_SYNC1 : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (frame_idx >= CAP_FIRST && frame_idx < CAP_FIRST + CAP_COUNT)
                        capture[frame_idx - CAP_FIRST] = b;
                    frame_idx++;
                    add_sum(b);
                    if (frame_idx >= frame_len) phase = PH_CK_A;
                end
                PH_CK_A: begin
                    rx_sum_a = b;
                    phase = PH_CK_B;
                end
                PH_CK_B: begin
                    if (sum_a == rx_sum_a && sum_b == b &&
                        frame_class == WANT_CLASS && frame_kind == WANT_KIND)
                        emit_telemetry();
                    phase = PH_SYNC1;
                end
                default: phase = PH_SYNC1;
            endcase
        endfunction

        function void check_tx_beat(logic [7:0] data, logic last);
            tx_beat_t want;
            if (tlm_expected.size() == 0) begin
                $display("%0t unexpected tx beat: expected none, actual data %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = tlm_expected.pop_front();
            if (data !== want.data) begin
                $display("%0t tx_byte mismatch: expected %02h, actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t frame_end mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
            if (want.last) frames_checked++;
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_addr;
    logic [7:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    telemetry_scoreboard sb;
    bit          no_idle;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          cycle_count;
    int          frame_beats;
    int          noise_beats;
    int          frames_sent;
    int          settings_used;

    gps_nav_frame_to_telemetry_bridge_core #(
        .MAX_PAYLOAD(MAX_LEN)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t timeout with %0d beats still expected", $time,
                     sb.tlm_expected.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.take_rx_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_tx_beat(m_tdata, m_tlast);
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] kind,
                              input logic [15:0] len, input ck_fault_e fault);
        logic [7:0]  ca;
        logic [7:0]  cb;
        logic [7:0]  b;
        int unsigned count;
        ca = '0;
        cb = '0;
        count = (len == 0) ? 1 : len;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < 4 + count; i++) begin
            case (i)
                0: b = cls;
                1: b = kind;
                2: b = len[7:0];
                3: b = len[15:8];
                default: b = $urandom_range(255);
            endcase
            ca = ca + b;
            cb = cb + ca;
            send_byte(b);
        end
        if (fault == CK_BAD_A || fault == CK_BAD_BOTH) ca = ca ^ 8'($urandom_range(1, 255));
        if (fault == CK_BAD_B || fault == CK_BAD_BOTH) cb = cb ^ 8'($urandom_range(1, 255));
        send_byte(ca);
        send_byte(cb);
        frame_beats += 8 + count;
        frames_sent++;
    endtask

    // header only: the parser drops the frame after the length
    task automatic send_oversized(input logic [15:0] len);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(WANT_CLASS);
        send_byte(WANT_KIND);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        frame_beats += 6;
        frames_sent++;
    endtask

    task automatic send_random_chunk();
        int unsigned pick;
        int unsigned sub;
        logic [15:0] len;
        pick = $urandom_range(99);
        len = ($urandom_range(99) < 30) ? 16'($urandom_range(23)) : 16'($urandom_range(24, 40));
        if (pick < 55) begin
            send_frame(WANT_CLASS, WANT_KIND, len, CK_GOOD);
        end else if (pick < 65) begin
            send_frame(WANT_CLASS, WANT_KIND, len, ck_fault_e'($urandom_range(1, 3)));
        end else if (pick < 75) begin
            sub = $urandom_range(2);
            case (sub)
                0: send_frame(WANT_CLASS, 8'($urandom_range(255)), len, CK_GOOD);
                1: send_frame(8'($urandom_range(255)), WANT_KIND, len, CK_GOOD);
                default: send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                                    CK_GOOD);
            endcase
        end else if (pick < 85) begin
            if ($urandom_range(1)) send_oversized(16'(MAX_LEN + 1));
            else send_oversized(16'($urandom_range(MAX_LEN + 1, 65535)));
        end else begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(8'($urandom_range(255)));
                noise_beats++;
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.tlm_expected.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] aircraft, input logic [7:0] msg);
        cfg_we <= 1'b1;
        cfg_addr <= REG_AIRCRAFT_ID;
        cfg_wdata <= aircraft;
        @(posedge aclk);
        cfg_addr <= REG_MSG_ID;
        cfg_wdata <= msg;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        sb.set_reg(REG_AIRCRAFT_ID, aircraft);
        sb.set_reg(REG_MSG_ID, msg);
        settings_used++;
    endtask

    initial begin
        int target;
        sb = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_AIRCRAFT_ID;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        no_idle = 1'b0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        cycle_count = 0;
        frame_beats = 0;
        noise_beats = 0;
        frames_sent = 0;
        settings_used = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bad second sync, then a sync byte that must not restart the hunt
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        noise_beats += 3;
        // zero length still takes one payload beat; captures are still clear
        send_frame(WANT_CLASS, WANT_KIND, 16'd0, CK_GOOD);
        send_oversized(16'(MAX_LEN + 1));
        send_frame(WANT_CLASS, WANT_KIND, 16'd0, CK_BAD_BOTH);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            case (p)
                0: set_config(8'h00, 8'hFF);
                1: set_config(8'hFF, 8'h00);
                2: set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
                default: set_config(8'hFF, 8'hFF);
            endcase
            no_idle = (p == 2);
            if (p == 1) begin
                hold_requests++;
                repeat (5) send_frame(WANT_CLASS, WANT_KIND, 16'd0, CK_GOOD);
            end
            if (p == 3) send_frame(WANT_CLASS, WANT_KIND, 16'd24, CK_GOOD);
            target = frame_beats + PHASE_BEATS;
            while (frame_beats < target) send_random_chunk();
        end
        no_idle = 1'b0;
        wait_idle();
        repeat (6) @(posedge aclk);

        $display("run covered %0d frame beats in %0d frames plus %0d noise beats",
                 frame_beats, frames_sent, noise_beats);
        $display("%0d telemetry frames checked across %0d id settings",
                 sb.frames_checked, settings_used);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
